@@ src/mfek_pkg.sv @@
// ----------------------------------------------------------------------------
// mfek_pkg: shared types and constants for the max-flow unit
// Widths, node limits and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mfek_pkg;
  localparam int unsigned MaxNodes  = 64;
  localparam int unsigned NodeBits  = $clog2(MaxNodes);
  localparam int unsigned CntBits   = NodeBits + 1;
  localparam int unsigned CapBits   = 16;
  localparam int unsigned ResBits   = CapBits + 1;
  localparam int unsigned FlowBits  = 22;
  localparam int unsigned AddrBits  = 2 * NodeBits;
  localparam int unsigned MemDepth  = MaxNodes * MaxNodes;
  localparam logic [FlowBits-1:0] FlowLimit = {FlowBits{1'b1}};

  localparam logic OpLoad    = 1'b0;
  localparam logic OpCompute = 1'b1;

  typedef struct packed {
    logic                bfs_start;  // clear marks but node 0's, seed queue with 0, bottleneck <= max
    logic                bfs_pop;    // load cur from queue head
    logic                scan_rd;    // read residual[cur][v]
    logic                scan_chk;   // use read data for node v
    logic                walk_init;  // v <= sink, step count cleared
    logic                walk_rd;    // read residual[parent[v]][v]
    logic                walk_min;   // fold read data into bottleneck
    logic                walk_step;  // v <= parent[v]
    logic                aug_fwd_rd; // read residual[u][v]
    logic                aug_fwd_wr; // write residual[u][v] - b
    logic                aug_bwd_rd; // read residual[v][u]
    logic                aug_bwd_wr; // write residual[v][u] + b
    logic                flow_add;
    logic                flow_clr;
    logic                clr_step;   // write zero at clear address, advance
    logic                load_wr;
    logic [NodeBits-1:0] load_from;
    logic [NodeBits-1:0] load_to;
    logic [CapBits-1:0]  load_cap;
  } dp_cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic scan_last;     // v is the last node in use
    logic sink_seen;
    logic walk_done;     // v == 0 or step limit reached
    logic clr_done;
  } dp_sts_t;
endpackage

@@ src/mfek_datapath.sv @@
// ----------------------------------------------------------------------------
// mfek_datapath: residual matrix, BFS queue, parents and flow accumulator
// One matrix access per cycle; the controller sequences every step.
// ----------------------------------------------------------------------------
module mfek_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [mfek_pkg::CntBits-1:0]       nodes_i,
  input  mfek_pkg::dp_cmd_t                  cmd_i,
  output mfek_pkg::dp_sts_t                  sts_o,
  output logic [mfek_pkg::FlowBits-1:0]      flow_o
);
  import mfek_pkg::*;

  logic [ResBits-1:0]  res_mem [MemDepth];
  logic [ResBits-1:0]  rd_q;
  logic [NodeBits-1:0] parent_mem [MaxNodes];
  logic [NodeBits-1:0] queue_mem  [MaxNodes];
  logic [NodeBits-1:0] par_q;
  logic [NodeBits-1:0] par_addr;
  logic [MaxNodes-1:0] visited_q;
  logic [CntBits-1:0]  head_q, tail_q;
  logic [NodeBits-1:0] cur_q, v_q, u_q;
  logic [CntBits-1:0]  steps_q;
  logic [ResBits-1:0]  bott_q;
  logic [FlowBits-1:0] flow_q;
  logic [AddrBits-1:0] clr_q;
  logic [NodeBits-1:0] sink;
  logic [AddrBits-1:0] addr;
  logic                we;
  logic [ResBits-1:0]  wdata;
  logic [FlowBits:0]   flow_sum;

  assign sink = NodeBits'(nodes_i - CntBits'(1));
  // parent of the node that v moves to next, registered into par_q and ready in the next cycle
  assign par_addr = cmd_i.walk_init ? sink : u_q;

  always_comb begin
    addr  = {cur_q, v_q};
    we    = 1'b0;
    wdata = '0;
    if (cmd_i.load_wr) begin
      addr = {cmd_i.load_from, cmd_i.load_to};
      we = 1'b1;
      wdata = {1'b0, cmd_i.load_cap};
    end else if (cmd_i.clr_step) begin
      addr = clr_q;
      we = 1'b1;
    end else if (cmd_i.walk_rd || cmd_i.aug_fwd_rd) begin
      addr = {par_q, v_q};
    end else if (cmd_i.aug_fwd_wr) begin
      addr = {u_q, v_q};
      we = 1'b1;
      wdata = rd_q - bott_q;
    end else if (cmd_i.aug_bwd_rd) begin
      addr = {v_q, u_q};
    end else if (cmd_i.aug_bwd_wr) begin
      addr = {v_q, u_q};
      we = 1'b1;
      wdata = rd_q + bott_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) res_mem[addr] <= wdata;
    rd_q <= res_mem[addr];
  end

  // queue and parent stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.bfs_start) queue_mem[0] <= '0;
    else if (cmd_i.scan_chk && !visited_q[v_q] && rd_q != '0) begin
      if (tail_q < CntBits'(MaxNodes)) queue_mem[tail_q[NodeBits-1:0]] <= v_q;
      parent_mem[v_q] <= cur_q;
    end
    par_q <= parent_mem[par_addr];
  end

  assign flow_sum = {1'b0, flow_q} + (FlowBits+1)'(bott_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      head_q <= '0; tail_q <= '0;
      cur_q <= '0; v_q <= '0; u_q <= '0;
      steps_q <= '0; bott_q <= '0; flow_q <= '0; clr_q <= '0;
    end else begin
      if (cmd_i.bfs_start) begin
        visited_q <= MaxNodes'(1);
        head_q <= '0;
        tail_q <= CntBits'(1);
        bott_q <= '1;
      end
      if (cmd_i.bfs_pop) begin
        cur_q <= queue_mem[head_q[NodeBits-1:0]];
        head_q <= head_q + CntBits'(1);
        v_q <= '0;
      end
      if (cmd_i.scan_chk) begin
        if (!visited_q[v_q] && rd_q != '0) begin
          visited_q[v_q] <= 1'b1;
          if (tail_q < CntBits'(MaxNodes)) tail_q <= tail_q + CntBits'(1);
        end
        v_q <= v_q + NodeBits'(1);
      end
      if (cmd_i.walk_init) begin
        v_q <= sink;
        steps_q <= '0;
      end
      if (cmd_i.walk_rd || cmd_i.aug_fwd_rd) u_q <= par_q;
      if (cmd_i.walk_min && rd_q < bott_q) bott_q <= rd_q;
      if (cmd_i.walk_step) begin
        v_q <= u_q;
        steps_q <= steps_q + CntBits'(1);
      end
      if (cmd_i.flow_clr) flow_q <= '0;
      else if (cmd_i.flow_add)
        flow_q <= (flow_sum > {1'b0, FlowLimit}) ? FlowLimit : flow_sum[FlowBits-1:0];
      if (cmd_i.clr_step) clr_q <= clr_q + AddrBits'(1);
    end
  end

  assign sts_o.queue_empty = (head_q == tail_q);
  assign sts_o.scan_last   = (v_q == sink);
  assign sts_o.sink_seen   = visited_q[sink];
  assign sts_o.walk_done   = (v_q == '0) || (steps_q == nodes_i);
  assign sts_o.clr_done    = (clr_q == '1);
  assign flow_o = flow_q;
endmodule

@@ src/mfek_ctrl.sv @@
// ----------------------------------------------------------------------------
// mfek_ctrl: sequencer for loads, searches, augmentation and matrix clear
// ----------------------------------------------------------------------------
module mfek_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [mfek_pkg::NodeBits-1:0] from_i,
  input  logic [mfek_pkg::NodeBits-1:0] to_i,
  input  logic [mfek_pkg::CapBits-1:0]  cap_i,
  input  logic [mfek_pkg::CntBits-1:0]  nodes_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mfek_pkg::dp_cmd_t             cmd_o,
  input  mfek_pkg::dp_sts_t             sts_i
);
  import mfek_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_BFS   = 14'b00000000000010,
    S_POP   = 14'b00000000000100,
    S_SRD   = 14'b00000000001000,
    S_SCHK  = 14'b00000000010000,
    S_WRD   = 14'b00000000100000,
    S_WMIN  = 14'b00000001000000,
    S_ARD   = 14'b00000010000000,
    S_AFW   = 14'b00000100000000,
    S_ABR   = 14'b00001000000000,
    S_ABW   = 14'b00010000000000,
    S_CLR   = 14'b00100000000000,
    S_OUT   = 14'b01000000000000,
    S_ICLR  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.load_from = from_i;
    cmd_o.load_to   = to_i;
    cmd_o.load_cap  = cap_i;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (op_i == OpLoad) begin
            cmd_o.load_wr = (CntBits'(from_i) < nodes_i) && (CntBits'(to_i) < nodes_i);
          end else begin
            cmd_o.flow_clr = 1'b1;
            state_d = S_BFS;
          end
        end
      end
      S_BFS: begin
        cmd_o.bfs_start = 1'b1;
        state_d = S_POP;
      end
      S_POP: begin
        if (sts_i.queue_empty) begin
          if (sts_i.sink_seen) begin
            cmd_o.walk_init = 1'b1;
            state_d = S_WRD;
          end else state_d = S_CLR;
        end else begin
          cmd_o.bfs_pop = 1'b1;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d = sts_i.scan_last ? S_POP : S_SRD;
      end
      S_WRD: begin
        if (sts_i.walk_done) begin
          cmd_o.walk_init = 1'b1;
          cmd_o.flow_add = 1'b1;
          state_d = S_ARD;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = S_WMIN;
        end
      end
      S_WMIN: begin
        cmd_o.walk_min = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d = S_WRD;
      end
      S_ARD: begin
        if (sts_i.walk_done) state_d = S_BFS;
        else begin
          cmd_o.aug_fwd_rd = 1'b1;
          state_d = S_AFW;
        end
      end
      S_AFW: begin
        cmd_o.aug_fwd_wr = 1'b1;
        state_d = S_ABR;
      end
      S_ABR: begin
        cmd_o.aug_bwd_rd = 1'b1;
        state_d = S_ABW;
      end
      S_ABW: begin
        cmd_o.aug_bwd_wr = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d = S_ARD;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      // matrix starts out zero: clear pass right after reset
      S_ICLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_ICLR;
    else state_q <= state_d;
  end
endmodule

@@ src/max_flow_edmonds_karp_unit.sv @@
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_unit: Edmonds-Karp maximum flow engine
// Channel  | dir | payload
// s_axis   | in  | tdata: operation, from_node, to_node, capacity
// m_axis   | out | tdata: total flow
// cfg      | in  | node_count
// A load item is written as it is accepted; a compute item runs searches
// (dequeue nodes, read and check matrix entries), per path a bottleneck walk
// from the sink and a read and write of each edge both ways, then a matrix
// clear, all through one matrix port. After reset a clear holds off input.
// Items are taken one at a time; input stalls until the result is taken.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // operation, from_node, to_node, capacity
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // total flow
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i    // node_count
);
  import mfek_pkg::*;

  logic [6:0]          node_count_q;
  logic [CntBits-1:0]  nodes;
  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [FlowBits-1:0] flow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) node_count_q <= 7'd2;
    else if (cfg_we_i) node_count_q <= cfg_wdata_i;
  end

  always_comb begin
    if (node_count_q < 7'd2) nodes = CntBits'(2);
    else if (node_count_q > 7'(MaxNodes)) nodes = CntBits'(MaxNodes);
    else nodes = CntBits'(node_count_q);
  end

  mfek_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[0]),
    .from_i     (s_axis_tdata[6:1]),
    .to_i       (s_axis_tdata[12:7]),
    .cap_i      (s_axis_tdata[28:13]),
    .nodes_i    (nodes),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mfek_datapath u_dp (
    .clk_i, .rst_ni,
    .nodes_i(nodes),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .flow_o (flow)
  );

  assign m_axis_tdata = {2'b00, flow};

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load_wr && cmd.clr_step)) else $error("two matrix writes");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_wr |-> s_axis_tready) else $error("load while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed");
endmodule
